// ===== src/per_label_color_box_stats_assert.svh =====
// Assertion macros for the per-label statistics block.
// PLCBS_ASSERT checks a property that holds in the same cycle.
// PLCBS_ASSERT_NEXT checks that a condition is followed by another in the next cycle.
// Both use the enclosing module's i_clk and i_rst_n.
`ifndef PER_LABEL_COLOR_BOX_STATS_ASSERT_SVH
`define PER_LABEL_COLOR_BOX_STATS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PLCBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PLCBS_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define PLCBS_ASSERT(lbl, prop, msg)
`define PLCBS_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

// ===== src/plcbs_pkg.sv =====
package plcbs_pkg;

    localparam int LABELS     = 1024;
    localparam int BINS       = 25;
    localparam int COUNT_BITS = 20;

    localparam int LABEL_W    = 10;
    localparam int LIDX_W     = $clog2(LABELS);
    localparam int BIN_W      = $clog2(BINS);
    localparam int HIST_DEPTH = LABELS * BINS;
    localparam int HADDR_W    = $clog2(HIST_DEPTH);
    localparam int OUT_W      = 21;
    localparam int SIDX_W     = 7;
    localparam int POS_W      = 12;
    localparam int SPACE_W    = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [SPACE_W-1:0] FAR_LIMIT_RESET = 16'sd1500;

    // Operation codes.
    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Statistic word indexes.
    localparam logic [SIDX_W-1:0] SI_COUNT   = 7'd0;
    localparam logic [SIDX_W-1:0] SI_COL_MIN = 7'd1;
    localparam logic [SIDX_W-1:0] SI_COL_MAX = 7'd2;
    localparam logic [SIDX_W-1:0] SI_ROW_MIN = 7'd3;
    localparam logic [SIDX_W-1:0] SI_ROW_MAX = 7'd4;
    localparam logic [SIDX_W-1:0] SI_X_MIN   = 7'd5;
    localparam logic [SIDX_W-1:0] SI_X_MAX   = 7'd6;
    localparam logic [SIDX_W-1:0] SI_Y_MIN   = 7'd7;
    localparam logic [SIDX_W-1:0] SI_Y_MAX   = 7'd8;
    localparam logic [SIDX_W-1:0] SI_Z_MIN   = 7'd9;
    localparam logic [SIDX_W-1:0] SI_Z_MAX   = 7'd10;
    localparam int BIN_BASE = 11;

    // Histogram bank selected by a read.
    localparam logic [1:0] HS_NONE  = 2'd0;
    localparam logic [1:0] HS_RED   = 2'd1;
    localparam logic [1:0] HS_GREEN = 2'd2;
    localparam logic [1:0] HS_BLUE  = 2'd3;

    typedef struct packed {
        logic [COUNT_BITS-1:0]     count;
        logic [POS_W-1:0]          col_min;
        logic [POS_W-1:0]          col_max;
        logic [POS_W-1:0]          row_min;
        logic [POS_W-1:0]          row_max;
        logic signed [SPACE_W-1:0] x_min;
        logic signed [SPACE_W-1:0] x_max;
        logic signed [SPACE_W-1:0] y_min;
        logic signed [SPACE_W-1:0] y_max;
        logic signed [SPACE_W-1:0] z_min;
        logic signed [SPACE_W-1:0] z_max;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        count:   '0,
        col_min: 12'd4095,
        col_max: 12'd0,
        row_min: 12'd4095,
        row_max: 12'd0,
        x_min:   16'sh7fff,
        x_max:   16'sh8000,
        y_min:   16'sh7fff,
        y_max:   16'sh8000,
        z_min:   16'sh7fff,
        z_max:   16'sh8000
    };

    typedef struct packed {
        logic [1:0]       sel;
        logic [BIN_W-1:0] bin;
    } t_rbin;

    typedef enum logic [3:0] {
        ST_INIT   = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_CLEAR  = 4'b1000
    } t_state;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // (c - 3) / 10 as * 205 / 2048, exact for 8-bit c; capped at bin 24.
    function automatic logic [BIN_W-1:0] color_bin(input logic [7:0] c);
        logic [7:0]  x;
        logic [16:0] p;
        logic [5:0]  q;
        x = (c < 8'd3) ? 8'd0 : c - 8'd3;
        p = 17'(x) * 17'd205;
        q = p[16:11];
        if (int'(q) > BINS - 1) begin
            return BIN_W'(BINS - 1);
        end
        return BIN_W'(q);
    endfunction

    function automatic t_rbin read_bin(input logic [SIDX_W-1:0] idx);
        t_rbin r;
        int    i;
        i = int'(idx);
        r.sel = HS_NONE;
        r.bin = '0;
        if (i >= BIN_BASE && i < BIN_BASE + BINS) begin
            r.sel = HS_RED;
            r.bin = BIN_W'(i - BIN_BASE);
        end else if (i >= BIN_BASE + BINS && i < BIN_BASE + 2 * BINS) begin
            r.sel = HS_GREEN;
            r.bin = BIN_W'(i - BIN_BASE - BINS);
        end else if (i >= BIN_BASE + 2 * BINS && i < BIN_BASE + 3 * BINS) begin
            r.sel = HS_BLUE;
            r.bin = BIN_W'(i - BIN_BASE - 2 * BINS);
        end
        return r;
    endfunction

    function automatic logic [HADDR_W-1:0] hist_addr(input logic [LIDX_W-1:0] lbl,
                                                      input logic [BIN_W-1:0] bin);
        return HADDR_W'(lbl) * HADDR_W'(BINS) + HADDR_W'(bin);
    endfunction

endpackage

// ===== src/plcbs_hist_bank.sv =====
module plcbs_hist_bank (
    input  logic                                i_clk,
    input  logic [plcbs_pkg::HADDR_W-1:0]       i_rd_addr,
    output logic [plcbs_pkg::COUNT_BITS-1:0]    o_rd_data,
    input  logic                                i_wr_en,
    input  logic [plcbs_pkg::HADDR_W-1:0]       i_wr_addr,
    input  logic [plcbs_pkg::COUNT_BITS-1:0]    i_wr_data
);

    logic [plcbs_pkg::COUNT_BITS-1:0] r_mem [plcbs_pkg::HIST_DEPTH];
    logic [plcbs_pkg::COUNT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/per_label_color_box_stats.sv =====
// Accumulate, read and unused op codes go through ST_UPDATE: the entry and the three
// histogram bins are read at the accepting edge, and an accumulate writes them back
// in the next cycle. A read result is registered in ST_UPDATE and strobed on o_valid
// for a single cycle. A clear resets the label's entry and histogram bins in ST_CLEAR,
// one bin of each bank per cycle. After reset a clearing pass in ST_INIT sweeps all
// memories; busy stays high until it ends. Configuration writes are taken at any time.
`include "per_label_color_box_stats_assert.svh"

module per_label_color_box_stats (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic [1:0]                              i_op,
    input  logic [plcbs_pkg::LABEL_W-1:0]           i_label,
    input  logic [7:0]                              i_red,
    input  logic [7:0]                              i_green,
    input  logic [7:0]                              i_blue,
    input  logic [plcbs_pkg::POS_W-1:0]             i_column,
    input  logic [plcbs_pkg::POS_W-1:0]             i_image_row,
    input  logic signed [plcbs_pkg::SPACE_W-1:0]    i_pos_x,
    input  logic signed [plcbs_pkg::SPACE_W-1:0]    i_pos_y,
    input  logic signed [plcbs_pkg::SPACE_W-1:0]    i_pos_z,
    input  logic [plcbs_pkg::SIDX_W-1:0]            i_stat_index,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic signed [plcbs_pkg::SPACE_W-1:0]    i_cfg_data,
    output logic                                    o_valid,
    output logic signed [plcbs_pkg::OUT_W-1:0]      o_stat_value,
    output logic                                    o_entry_empty
);

    localparam int CB = plcbs_pkg::COUNT_BITS;
    localparam int HW = plcbs_pkg::HADDR_W;

    plcbs_pkg::t_state r_state, n_state;

    logic signed [plcbs_pkg::SPACE_W-1:0] r_far_limit;
    logic [HW-1:0]                        r_init_cnt;
    logic [plcbs_pkg::BIN_W-1:0]          r_bin;

    // Item fields held for the write-back cycle.
    logic [1:0]                           r_op;
    logic [plcbs_pkg::LIDX_W-1:0]         r_lidx;
    logic                                 r_label_ok;
    logic [plcbs_pkg::POS_W-1:0]          r_column;
    logic [plcbs_pkg::POS_W-1:0]          r_row;
    logic signed [plcbs_pkg::SPACE_W-1:0] r_pos_x;
    logic signed [plcbs_pkg::SPACE_W-1:0] r_pos_y;
    logic signed [plcbs_pkg::SPACE_W-1:0] r_pos_z;
    logic [plcbs_pkg::SIDX_W-1:0]         r_stat_index;
    logic [1:0]                           r_hsel;
    logic [HW-1:0]                        r_haddr [3];

    logic                                 r_valid;
    logic signed [plcbs_pkg::OUT_W-1:0]   r_stat_value;
    logic                                 r_empty;

    plcbs_pkg::t_entry r_entry_mem [plcbs_pkg::LABELS];
    plcbs_pkg::t_entry r_entry_q;

    logic                          accept;
    logic                          label_ok;
    logic [plcbs_pkg::LIDX_W-1:0]  lidx;
    plcbs_pkg::t_rbin              rbin;
    logic [HW-1:0]                 hist_ra [3];
    logic [CB-1:0]                 hist_rd [3];
    logic                          hist_we;
    logic [HW-1:0]                 hist_wa [3];
    logic [CB-1:0]                 hist_wd [3];
    logic                          ent_we;
    logic [plcbs_pkg::LIDX_W-1:0]  ent_wa;
    plcbs_pkg::t_entry             ent_wd;
    plcbs_pkg::t_entry             ent_upd;
    logic signed [plcbs_pkg::OUT_W-1:0] word;

    assign accept      = i_start && (r_state == plcbs_pkg::ST_IDLE);
    assign o_busy      = (r_state != plcbs_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign label_ok    = int'(i_label) < plcbs_pkg::LABELS;
    assign lidx        = plcbs_pkg::LIDX_W'(i_label);
    assign rbin        = plcbs_pkg::read_bin(i_stat_index);

    // A read uses the same row in every bank; only the selected bank's word is used.
    always_comb begin
        if (i_op == plcbs_pkg::OP_READ) begin
            hist_ra[0] = plcbs_pkg::hist_addr(lidx, rbin.bin);
            hist_ra[1] = hist_ra[0];
            hist_ra[2] = hist_ra[0];
        end else begin
            hist_ra[0] = plcbs_pkg::hist_addr(lidx, plcbs_pkg::color_bin(i_red));
            hist_ra[1] = plcbs_pkg::hist_addr(lidx, plcbs_pkg::color_bin(i_green));
            hist_ra[2] = plcbs_pkg::hist_addr(lidx, plcbs_pkg::color_bin(i_blue));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            plcbs_pkg::ST_INIT: begin
                if (r_init_cnt == HW'(plcbs_pkg::HIST_DEPTH - 1)) begin
                    n_state = plcbs_pkg::ST_IDLE;
                end
            end
            plcbs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_op == plcbs_pkg::OP_CLEAR) ? plcbs_pkg::ST_CLEAR
                                                             : plcbs_pkg::ST_UPDATE;
                end
            end
            plcbs_pkg::ST_UPDATE: begin
                n_state = plcbs_pkg::ST_IDLE;
            end
            plcbs_pkg::ST_CLEAR: begin
                if (r_bin == plcbs_pkg::BIN_W'(plcbs_pkg::BINS - 1)) begin
                    n_state = plcbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plcbs_pkg::ST_INIT;
            end
        endcase
    end

    // New entry for an accumulated pixel.
    always_comb begin
        ent_upd       = r_entry_q;
        ent_upd.count = plcbs_pkg::sat_inc(r_entry_q.count);
        if (r_column < r_entry_q.col_min) ent_upd.col_min = r_column;
        if (r_column > r_entry_q.col_max) ent_upd.col_max = r_column;
        if (r_row < r_entry_q.row_min) ent_upd.row_min = r_row;
        if (r_row > r_entry_q.row_max) ent_upd.row_max = r_row;
        if (r_pos_x < r_entry_q.x_min) ent_upd.x_min = r_pos_x;
        if (r_pos_x > r_entry_q.x_max) ent_upd.x_max = r_pos_x;
        if (r_pos_y < r_entry_q.y_min) ent_upd.y_min = r_pos_y;
        if (r_pos_y > r_entry_q.y_max) ent_upd.y_max = r_pos_y;
        if (r_pos_z <= r_far_limit) begin
            if (r_pos_z < r_entry_q.z_min) ent_upd.z_min = r_pos_z;
            if (r_pos_z > r_entry_q.z_max) ent_upd.z_max = r_pos_z;
        end
    end

    // Write ports of the entry memory and the histogram banks.
    always_comb begin
        ent_we  = 1'b0;
        ent_wa  = r_lidx;
        ent_wd  = plcbs_pkg::ENTRY_RESET;
        hist_we = 1'b0;
        for (int k = 0; k < 3; k++) begin
            hist_wa[k] = r_haddr[k];
            hist_wd[k] = '0;
        end
        case (r_state)
            plcbs_pkg::ST_INIT: begin
                hist_we = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    hist_wa[k] = r_init_cnt;
                end
                ent_we = int'(r_init_cnt) < plcbs_pkg::LABELS;
                ent_wa = plcbs_pkg::LIDX_W'(r_init_cnt);
            end
            plcbs_pkg::ST_UPDATE: begin
                if (r_op == plcbs_pkg::OP_ACC && r_label_ok) begin
                    ent_we  = 1'b1;
                    ent_wd  = ent_upd;
                    hist_we = 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        hist_wd[k] = plcbs_pkg::sat_inc(hist_rd[k]);
                    end
                end
            end
            plcbs_pkg::ST_CLEAR: begin
                ent_we  = r_label_ok;
                hist_we = r_label_ok;
                for (int k = 0; k < 3; k++) begin
                    hist_wa[k] = plcbs_pkg::hist_addr(r_lidx, r_bin);
                end
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    // Statistic word selection for a read.
    always_comb begin
        word = '0;
        case (r_stat_index)
            plcbs_pkg::SI_COUNT:   word = plcbs_pkg::OUT_W'(r_entry_q.count);
            plcbs_pkg::SI_COL_MIN: word = plcbs_pkg::OUT_W'(r_entry_q.col_min);
            plcbs_pkg::SI_COL_MAX: word = plcbs_pkg::OUT_W'(r_entry_q.col_max);
            plcbs_pkg::SI_ROW_MIN: word = plcbs_pkg::OUT_W'(r_entry_q.row_min);
            plcbs_pkg::SI_ROW_MAX: word = plcbs_pkg::OUT_W'(r_entry_q.row_max);
            plcbs_pkg::SI_X_MIN:   word = plcbs_pkg::OUT_W'(r_entry_q.x_min);
            plcbs_pkg::SI_X_MAX:   word = plcbs_pkg::OUT_W'(r_entry_q.x_max);
            plcbs_pkg::SI_Y_MIN:   word = plcbs_pkg::OUT_W'(r_entry_q.y_min);
            plcbs_pkg::SI_Y_MAX:   word = plcbs_pkg::OUT_W'(r_entry_q.y_max);
            plcbs_pkg::SI_Z_MIN:   word = plcbs_pkg::OUT_W'(r_entry_q.z_min);
            plcbs_pkg::SI_Z_MAX:   word = plcbs_pkg::OUT_W'(r_entry_q.z_max);
            default: begin
                case (r_hsel)
                    plcbs_pkg::HS_RED:   word = plcbs_pkg::OUT_W'(hist_rd[0]);
                    plcbs_pkg::HS_GREEN: word = plcbs_pkg::OUT_W'(hist_rd[1]);
                    plcbs_pkg::HS_BLUE:  word = plcbs_pkg::OUT_W'(hist_rd[2]);
                    default:             word = '0;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_entry_mem[ent_wa] <= ent_wd;
        end
        r_entry_q <= r_entry_mem[lidx];
    end

    for (genvar k = 0; k < 3; k++) begin : g_bank
        plcbs_hist_bank u_bank (
            .i_clk     (i_clk),
            .i_rd_addr (hist_ra[k]),
            .o_rd_data (hist_rd[k]),
            .i_wr_en   (hist_we),
            .i_wr_addr (hist_wa[k]),
            .i_wr_data (hist_wd[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= plcbs_pkg::ST_INIT;
            r_far_limit   <= plcbs_pkg::FAR_LIMIT_RESET;
            r_init_cnt    <= '0;
            r_bin         <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_far_limit <= i_cfg_data;
            end
            if (r_state == plcbs_pkg::ST_INIT) begin
                r_init_cnt <= r_init_cnt + 1'b1;
            end
            if (r_state == plcbs_pkg::ST_CLEAR) begin
                r_bin <= r_bin + 1'b1;
            end else begin
                r_bin <= '0;
            end
            r_valid <= (r_state == plcbs_pkg::ST_UPDATE) && (r_op == plcbs_pkg::OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_op;
            r_lidx       <= lidx;
            r_label_ok   <= label_ok;
            r_column     <= i_column;
            r_row        <= i_image_row;
            r_pos_x      <= i_pos_x;
            r_pos_y      <= i_pos_y;
            r_pos_z      <= i_pos_z;
            r_stat_index <= i_stat_index;
            r_hsel       <= rbin.sel;
            for (int k = 0; k < 3; k++) begin
                r_haddr[k] <= hist_ra[k];
            end
        end
        if (r_state == plcbs_pkg::ST_UPDATE) begin
            r_stat_value <= r_label_ok ? word : '0;
            r_empty      <= r_label_ok ? (r_entry_q.count == '0) : 1'b1;
        end
    end

    assign o_valid       = r_valid;
    assign o_stat_value  = r_stat_value;
    assign o_entry_empty = r_empty;

    `PLCBS_ASSERT(a_state_onehot, $onehot(r_state), "state register is not one-hot")
    `PLCBS_ASSERT(a_valid_after_read,
        !o_valid || ($past(r_state == plcbs_pkg::ST_UPDATE) && $past(r_op == plcbs_pkg::OP_READ)),
        "result strobe without a read in the previous cycle")
    `PLCBS_ASSERT_NEXT(a_accept_works, i_start && !o_busy,
        r_state == plcbs_pkg::ST_UPDATE || r_state == plcbs_pkg::ST_CLEAR,
        "accepted item did not start work")
    `PLCBS_ASSERT_NEXT(a_clear_ends,
        r_state == plcbs_pkg::ST_CLEAR && r_bin == plcbs_pkg::BIN_W'(plcbs_pkg::BINS - 1),
        r_state == plcbs_pkg::ST_IDLE, "clear did not end after the last bin")

endmodule
